/* rtl/dss_pkg.sv */
// Shared types and constants of the memory-domain stall unit.
package dss_pkg;

	localparam int unsigned MD_W          = 63;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned RID_W         = 6;
	localparam int unsigned OP_W          = 3;
	localparam int unsigned CNT_W         = 6;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 6;
	localparam int unsigned HIGH_MD_SHIFT = 31;
	localparam int unsigned MAX_REQ       = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_CNT = 2'd1;

	typedef enum logic [OP_W-1:0] {
		OP_WR_LOW  = 3'd0,
		OP_WR_HIGH = 3'd1,
		OP_LOAD    = 3'd2,
		OP_QUERY   = 3'd3,
		OP_RD_LOW  = 3'd4,
		OP_RD_HIGH = 3'd5
	} op_t;

	// Control of one cell
	typedef struct packed {
		logic shift;
		logic ld;
	} cell_ctl_t;

	// Control of the whole ring
	typedef struct packed {
		logic shift;
		logic sweep;
		logic exempt;
		logic ld;
	} ring_ctl_t;

	// Bitmap of the implemented domains for a given domain count
	function automatic logic [MD_W-1:0] impl_mask(input logic [CNT_W-1:0] n);
		logic [63:0] m;
		m = (64'd1 << n) - 64'd1;
		return m[MD_W-1:0];
	endfunction

endpackage

/* rtl/dss_cell.sv */
// One ring cell: a requester's domain bitmap and its latched stall bit.
module dss_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dss_pkg::cell_ctl_t          ctl,
	input  logic [dss_pkg::MD_W-1:0]    nbr_bmp,
	input  logic                        nbr_stall,
	input  logic [dss_pkg::MD_W-1:0]    ld_bmp,
	output logic [dss_pkg::MD_W-1:0]    bmp,
	output logic                        stall
);

	logic [dss_pkg::MD_W-1:0] bmp_q;
	logic                     stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmp_q   <= '0;
			stall_q <= 1'b0;
		end else if (ctl.ld) begin
			bmp_q <= ld_bmp;
		end else if (ctl.shift) begin
			bmp_q   <= nbr_bmp;
			stall_q <= nbr_stall;
		end
	end

	assign bmp   = bmp_q;
	assign stall = stall_q;

endmodule

/* rtl/dss_ring.sv */
// Rotating ring of requester cells with the stall recompute at the wrap point.
module dss_ring #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dss_pkg::ring_ctl_t          ctl,
	input  logic [dss_pkg::MD_W-1:0]    sel,
	input  logic [dss_pkg::MD_W-1:0]    ld_bmp,
	output logic                        head_stall
);

	logic [dss_pkg::MD_W-1:0] bmp_w     [DEPTH];
	logic                     stall_w   [DEPTH];
	logic [dss_pkg::MD_W-1:0] nbr_bmp_w [DEPTH];
	logic                     nbr_stl_w [DEPTH];
	logic                     wrap_stall;

	// Head entry moves to the tail; during a sweep it takes its new stall bit
	assign wrap_stall = ctl.sweep ? (ctl.exempt ^ (|(bmp_w[0] & sel))) : stall_w[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dss_pkg::cell_ctl_t cctl;

		if (i == DEPTH - 1) begin : g_tail
			assign nbr_bmp_w[i] = bmp_w[0];
			assign nbr_stl_w[i] = wrap_stall;
		end else begin : g_body
			assign nbr_bmp_w[i] = bmp_w[i+1];
			assign nbr_stl_w[i] = stall_w[i+1];
		end

		assign cctl.shift = ctl.shift;
		assign cctl.ld    = (i == 0) ? ctl.ld : 1'b0;

		dss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cctl),
			.nbr_bmp   (nbr_bmp_w[i]),
			.nbr_stall (nbr_stl_w[i]),
			.ld_bmp    (ld_bmp),
			.bmp       (bmp_w[i]),
			.stall     (stall_w[i])
		);
	end

	assign head_stall = stall_w[0];

endmodule

/* rtl/domain_stall_snapshot.sv */
// Top level of the memory-domain stall unit: control sequencer, registers, result word.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: operation,
//   write_value, requester_id, domain_bitmap. Output channel (out_valid /
//   out_stall) returns one result word per command: read_data, is_stalled.
//   The configuration channel (cfg_valid / cfg_ready, always ready) writes
//   stall_enable (index 0) and domain_count (index 1); the user must write them
//   only while the unit is idle, and the block itself does not enforce it.
// Sequencing (DEPTH = REQUESTER_COUNT cells, at most 64):
//   Requester state lives in a ring of cells that rotates one place per cycle
//   while a command seeks or sweeps. Register reads, high writes, low writes
//   with stall_enable clear and ignored commands go from idle straight to the
//   done state and then into the output register. A bitmap load or stall query
//   rotates the ring until the requester reaches the head cell. A low write with
//   stall_enable set walks the whole ring once to latch every stall bit. One
//   command is in work at a time; in_stall is high until its result is moved
//   into the output register, so no new command is accepted before then.
// Reset clears the ring (all bitmaps and stall bits zero), both stall
//   registers, sets stall_enable to 1 and domain_count to 63.
// A stalled result word holds in the output register; the next command may
//   be accepted meanwhile but cannot finish until that word is taken.
module domain_stall_snapshot #(
	parameter int unsigned REQUESTER_COUNT = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [dss_pkg::OP_W-1:0]          operation,
	input  logic [dss_pkg::WORD_W-1:0]        write_value,
	input  logic [dss_pkg::RID_W-1:0]         requester_id,
	input  logic [dss_pkg::MD_W-1:0]          domain_bitmap,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [dss_pkg::WORD_W-1:0]        read_data,
	output logic                              is_stalled
);

	// Only requester ids 0..63 can be addressed, so at most 64 cells exist
	localparam int unsigned DEPTH = (REQUESTER_COUNT < dss_pkg::MAX_REQ) ?
	                                REQUESTER_COUNT : dss_pkg::MAX_REQ;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SEEK  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                          state_q;
	dss_pkg::op_t                    op_q;
	logic [dss_pkg::RID_W-1:0]       rid_q;
	logic [dss_pkg::MD_W-1:0]        bmp_q;
	logic [dss_pkg::MD_W-1:0]        sel_q;
	logic                            exempt_q;
	logic [IDX_W-1:0]                hq_q;      // id of the entry in the head cell
	logic [IDX_W-1:0]                cnt_q;     // sweep step
	logic [dss_pkg::WORD_W-1:0]      res_rdata_q;
	logic                            res_stall_q;

	logic                            stall_en_q;
	logic [dss_pkg::CNT_W-1:0]       dom_cnt_q;
	logic [dss_pkg::WORD_W-1:0]      low_q;
	logic [dss_pkg::WORD_W-1:0]      high_q;

	logic                            out_valid_q;
	logic [dss_pkg::WORD_W-1:0]      read_data_q;
	logic                            is_stalled_q;

	logic                            accept;
	logic                            out_free;
	logic                            in_range;
	logic                            hit;
	logic                            many_md;
	logic [dss_pkg::MD_W-1:0]        mask;
	logic [dss_pkg::MD_W-1:0]        sel_new;
	logic                            head_stall;
	dss_pkg::op_t                    op_in;
	dss_pkg::ring_ctl_t              ring_ctl;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign op_in     = dss_pkg::op_t'(operation);

	assign in_range = ({1'b0, requester_id} < 7'(DEPTH));
	assign hit      = (dss_pkg::RID_W'(hq_q) == rid_q);
	assign many_md  = (dom_cnt_q > 6'd31);
	assign mask     = dss_pkg::impl_mask(dom_cnt_q);

	// Full selection: MD 0..30 from the low write, MD 31..62 from high_q above 31 domains
	always_comb begin
		sel_new = {32'd0, write_value[dss_pkg::WORD_W-1:1]};
		if (many_md) begin
			sel_new = sel_new | {high_q, 31'd0};
		end
		sel_new = sel_new & mask;
	end

	// Ring control: rotate while seeking to a hit or sweeping, load in place on a load hit
	always_comb begin
		ring_ctl.shift  = ((state_q == S_SEEK) && !hit) || (state_q == S_SWEEP);
		ring_ctl.sweep  = (state_q == S_SWEEP);
		ring_ctl.exempt = exempt_q;
		ring_ctl.ld     = (state_q == S_SEEK) && hit && (op_q == dss_pkg::OP_LOAD);
	end

	dss_ring #(
		.DEPTH (DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.sel        (sel_q),
		.ld_bmp     (bmp_q),
		.head_stall (head_stall)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_en_q <= 1'b1;
			dom_cnt_q  <= 6'd63;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dss_pkg::CFG_STALL_EN:   stall_en_q <= cfg_data[0];
				dss_pkg::CFG_DOMAIN_CNT: dom_cnt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command payload, latched on acceptance; selection and exempt bit on low writes only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			rid_q <= requester_id;
			bmp_q <= domain_bitmap;
			if (op_in == dss_pkg::OP_WR_LOW) begin
				sel_q    <= sel_new;
				exempt_q <= write_value[0];
			end
		end
	end

	// Sequencer, stall registers and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hq_q        <= '0;
			cnt_q       <= '0;
			low_q       <= '0;
			high_q      <= '0;
			res_rdata_q <= '0;
			res_stall_q <= 1'b0;
		end else begin
			if (ring_ctl.shift) begin
				hq_q <= (hq_q == LAST) ? '0 : hq_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_stall_q <= 1'b0;
						unique case (op_in)
							dss_pkg::OP_WR_LOW: begin
								res_rdata_q <= '0;
								if (stall_en_q) begin
									low_q   <= {sel_new[30:0], 1'b0};
									state_q <= S_SWEEP;
								end else begin
									state_q <= S_DONE;
								end
							end
							dss_pkg::OP_WR_HIGH: begin
								res_rdata_q <= '0;
								state_q     <= S_DONE;
								if (stall_en_q && many_md) begin
									high_q <= write_value &
									          mask[dss_pkg::MD_W-1:dss_pkg::HIGH_MD_SHIFT];
								end
							end
							dss_pkg::OP_LOAD: begin
								res_rdata_q <= '0;
								state_q     <= in_range ? S_SEEK : S_DONE;
							end
							dss_pkg::OP_QUERY: begin
								res_rdata_q <= '0;
								state_q     <= (stall_en_q && in_range) ? S_SEEK : S_DONE;
							end
							dss_pkg::OP_RD_LOW: begin
								res_rdata_q <= stall_en_q ? low_q : '0;
								state_q     <= S_DONE;
							end
							dss_pkg::OP_RD_HIGH: begin
								res_rdata_q <= stall_en_q ? high_q : '0;
								state_q     <= S_DONE;
							end
							default: begin
								res_rdata_q <= '0;
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_SEEK: begin
					if (hit) begin
						if (op_q == dss_pkg::OP_QUERY) begin
							res_stall_q <= head_stall;
						end
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					// one full lap brings the head pointer back where it started
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: hold while stalled, load when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			read_data_q  <= res_rdata_q;
			is_stalled_q <= res_stall_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign is_stalled = is_stalled_q;

	// A result word only appears after the sequencer finished a command
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word without a finished command");

	// Seeking only happens for a requester that has a cell
	a_seek_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK) |-> ({1'b0, rid_q} < 7'(DEPTH)))
		else $error("seek toward a requester outside the ring");

	// Sweep counter rests at zero outside a sweep
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SWEEP) |-> (cnt_q == '0))
		else $error("sweep counter not cleared");

endmodule
